>>> sv/eul2dcm_pkg.sv
// ----------------------------------------------------------------------------
// eul2dcm_pkg
// Shared widths, constants and types for the 3-2-1 direction cosine matrix
// ----------------------------------------------------------------------------
package eul2dcm_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 14;

  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 16;
  localparam int N_OUT   = 9;
  localparam int IN_TW   = 3 * ANGLE_W;
  localparam int OUT_TW  = N_OUT * OUT_W;

  // q2.30 magnitudes never exceed 1.0, so 31 bits hold them
  localparam int MAG_W = 31;
  // series terms and products of the first quadrant fit 32 bits
  localparam int TW    = 32;
  localparam int ACC_W = 34;

  localparam int SERIES_TERMS = 8;
  // x stage, x squared stage, three stages a term, clamp and quadrant stage
  localparam int TRIG_LAT     = 3 * SERIES_TERMS + 3;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [30:0]      PI_HALF_Q30 = 31'd1686629713;
  localparam logic [MAG_W-1:0] ONE_Q30     = 31'h4000_0000;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  typedef struct packed {
    sm_t s;
    sm_t c;
  } trig_t;

  typedef struct packed {
    trig_t roll;
    trig_t pitch;
    trig_t yaw;
  } trig6_t;

endpackage

>>> sv/euler_angles_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// Roll, pitch and yaw to the 3-2-1 direction cosine matrix, fixed point
// ----------------------------------------------------------------------------
// Takes one word of three signed binary angles per clock (half a turn is
// 2^(ANGLE_BITS-1)) and returns the nine matrix entries that rotate
// north-east-down axes into body axes, each rounded to FRACTION_BITS fraction
// bits and saturated to +-1.0. The block is fully pipelined and sustains one
// word per clock while the output is not stalled. Most of the latency comes
// from the sine / cosine series, which spends three stages on each of its
// eight terms (term product, reciprocal estimate, quotient correction). A
// four-word queue sits between the trig pipelines and the product pipeline,
// so a stalled output only holds off new input once that queue has filled.
module euler_angles_to_rotation_matrix #(
  parameter int ANGLE_BITS    = eul2dcm_pkg::ANGLE_BITS_DEF,
  parameter int FRACTION_BITS = eul2dcm_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
  input  logic [eul2dcm_pkg::IN_TW-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33, 16 bits each from bit 0 up
  output logic [eul2dcm_pkg::OUT_TW-1:0] out_tdata
);
  import eul2dcm_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_nempty;
  trig6_t q_wdata;
  trig6_t q_rdata;

  eul2dcm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .roll     (in_tdata[ANGLE_W-1:0]),
    .pitch    (in_tdata[2*ANGLE_W-1:ANGLE_W]),
    .yaw      (in_tdata[3*ANGLE_W-1:2*ANGLE_W]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  eul2dcm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_nempty)
  );

  eul2dcm_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nempty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (out_tdata)
  );

endmodule

>>> sv/eul2dcm_trig.sv
// ----------------------------------------------------------------------------
// eul2dcm_trig
// Pipelined sine and cosine of one binary angle, q2.30 sign and magnitude
// ----------------------------------------------------------------------------
module eul2dcm_trig #(
  parameter int ANGLE_BITS = eul2dcm_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [eul2dcm_pkg::ANGLE_W-1:0] angle,
  output eul2dcm_pkg::trig_t             trig
);
  import eul2dcm_pkg::*;

  localparam int          SHIFT    = 32 - ANGLE_BITS;
  localparam logic [63:0] AMASK    = (64'd1 << ANGLE_BITS) - 64'd1;
  localparam bit          SUB_LAST = (SERIES_TERMS % 2) == 1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // ps / pc carry the running sine / cosine term, es / ec the quotient guess
  typedef struct packed {
    logic [1:0]       quad;
    logic [TW-1:0]    x2;
    logic [TW-1:0]    ps;
    logic [TW-1:0]    pc;
    logic [TW-1:0]    es;
    logic [TW-1:0]    ec;
    logic [ACC_W-1:0] s;
    logic [ACC_W-1:0] c;
  } term_t;

  function automatic logic [MAG_W-1:0] clamp_q30(input logic [ACC_W-1:0] v);
    logic [MAG_W-1:0] r;
    if (v[ACC_W-1]) begin
      r = '0;
    end else if (v > ACC_W'(ONE_Q30)) begin
      r = ONE_Q30;
    end else begin
      r = v[MAG_W-1:0];
    end
    return r;
  endfunction

  logic [63:0]   ang_ext;
  logic [31:0]   turn;
  logic [60:0]   xprod;
  logic [1:0]    quad1_r;
  logic [TW-1:0] x1_r;
  logic [63:0]   x2prod;
  term_t         init_nxt;
  term_t         init_r;
  term_t         a_r [SERIES_TERMS];
  term_t         b_r [SERIES_TERMS];
  term_t         c_r [SERIES_TERMS];
  logic [ACC_W-1:0] s_fin;
  logic [ACC_W-1:0] c_fin;
  logic [MAG_W-1:0] s_cl;
  logic [MAG_W-1:0] c_cl;
  trig_t         trig_nxt;
  trig_t         trig_r;

  // angle to a 32-bit turn, top two bits pick the quadrant
  assign ang_ext = {{(64-ANGLE_W){1'b0}}, angle} & AMASK;
  assign turn    = ang_ext[31:0] << SHIFT;
  assign xprod   = 61'(turn[29:0]) * 61'(PI_HALF_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      quad1_r <= turn[31:30];
      x1_r    <= TW'(xprod[60:30]);
    end
  end

  assign x2prod = 64'(x1_r) * 64'(x1_r);

  always_comb begin
    init_nxt.quad = quad1_r;
    init_nxt.x2   = x2prod[61:30];
    init_nxt.ps   = x1_r;
    init_nxt.pc   = TW'(ONE_Q30);
    init_nxt.es   = '0;
    init_nxt.ec   = '0;
    init_nxt.s    = ACC_W'(x1_r);
    init_nxt.c    = ACC_W'(ONE_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      init_r <= init_nxt;
    end
  end

  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
    localparam int          K        = i + 1;
    localparam logic [63:0] DS       = 64'((2 * K) * (2 * K + 1));
    localparam logic [63:0] DC       = 64'((2 * K - 1) * (2 * K));
    localparam logic [63:0] MS       = 64'h1_0000_0000 / DS;
    localparam logic [63:0] MC       = 64'h1_0000_0000 / DC;
    localparam bit          HAS_PREV = i > 0;
    localparam bit          SUB_PREV = (i % 2) == 1;

    term_t       src;
    term_t       a_nxt;
    term_t       b_nxt;
    term_t       c_nxt;
    logic [63:0] ms;
    logic [63:0] mc;
    logic [63:0] qs;
    logic [63:0] qc;
    logic [63:0] eds;
    logic [63:0] edc;
    logic [TW-1:0] rem_s;
    logic [TW-1:0] rem_c;

    if (i == 0) begin : g_first
      assign src = init_r;
    end else begin : g_next
      assign src = c_r[i-1];
    end

    // term times x squared; the previous term is folded into the sums here
    assign ms = 64'(src.ps) * 64'(src.x2);
    assign mc = 64'(src.pc) * 64'(src.x2);

    always_comb begin
      a_nxt    = src;
      a_nxt.ps = ms[61:30];
      a_nxt.pc = mc[61:30];
      if (HAS_PREV) begin
        if (SUB_PREV) begin
          a_nxt.s = src.s - ACC_W'(src.ps);
          a_nxt.c = src.c - ACC_W'(src.pc);
        end else begin
          a_nxt.s = src.s + ACC_W'(src.ps);
          a_nxt.c = src.c + ACC_W'(src.pc);
        end
      end
    end

    // reciprocal estimate, low by at most one
    assign qs = 64'(a_r[i].ps) * MS;
    assign qc = 64'(a_r[i].pc) * MC;

    always_comb begin
      b_nxt    = a_r[i];
      b_nxt.es = qs[63:32];
      b_nxt.ec = qc[63:32];
    end

    assign eds   = 64'(b_r[i].es) * DS;
    assign edc   = 64'(b_r[i].ec) * DC;
    assign rem_s = b_r[i].ps - eds[TW-1:0];
    assign rem_c = b_r[i].pc - edc[TW-1:0];

    always_comb begin
      c_nxt    = b_r[i];
      c_nxt.ps = (rem_s >= DS[TW-1:0]) ? b_r[i].es + TW'(1) : b_r[i].es;
      c_nxt.pc = (rem_c >= DC[TW-1:0]) ? b_r[i].ec + TW'(1) : b_r[i].ec;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i] <= a_nxt;
        b_r[i] <= b_nxt;
        c_r[i] <= c_nxt;
      end
    end
  end

  assign s_fin = SUB_LAST ? c_r[SERIES_TERMS-1].s - ACC_W'(c_r[SERIES_TERMS-1].ps)
                          : c_r[SERIES_TERMS-1].s + ACC_W'(c_r[SERIES_TERMS-1].ps);
  assign c_fin = SUB_LAST ? c_r[SERIES_TERMS-1].c - ACC_W'(c_r[SERIES_TERMS-1].pc)
                          : c_r[SERIES_TERMS-1].c + ACC_W'(c_r[SERIES_TERMS-1].pc);
  assign s_cl  = clamp_q30(s_fin);
  assign c_cl  = clamp_q30(c_fin);

  always_comb begin
    case (c_r[SERIES_TERMS-1].quad)
      QUAD_0: begin
        trig_nxt.s = '{neg: 1'b0, mag: s_cl};
        trig_nxt.c = '{neg: 1'b0, mag: c_cl};
      end
      QUAD_1: begin
        trig_nxt.s = '{neg: 1'b0, mag: c_cl};
        trig_nxt.c = '{neg: 1'b1, mag: s_cl};
      end
      QUAD_2: begin
        trig_nxt.s = '{neg: 1'b1, mag: s_cl};
        trig_nxt.c = '{neg: 1'b1, mag: c_cl};
      end
      default: begin
        trig_nxt.s = '{neg: 1'b1, mag: c_cl};
        trig_nxt.c = '{neg: 1'b0, mag: s_cl};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

>>> sv/eul2dcm_front.sv
// ----------------------------------------------------------------------------
// eul2dcm_front
// Input register and three lockstep sine / cosine pipelines
// ----------------------------------------------------------------------------
module eul2dcm_front #(
  parameter int ANGLE_BITS = eul2dcm_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [eul2dcm_pkg::ANGLE_W-1:0] roll,
  input  logic [eul2dcm_pkg::ANGLE_W-1:0] pitch,
  input  logic [eul2dcm_pkg::ANGLE_W-1:0] yaw,
  input  logic                            q_full,
  output logic                            q_push,
  output eul2dcm_pkg::trig6_t             q_data
);
  import eul2dcm_pkg::*;

  logic               fen;
  logic               fv_r [TRIG_LAT+1];
  logic [ANGLE_W-1:0] roll_r;
  logic [ANGLE_W-1:0] pitch_r;
  logic [ANGLE_W-1:0] yaw_r;

  // the pipe only holds when a finished word cannot enter the queue
  assign fen      = !(fv_r[TRIG_LAT] && q_full);
  assign in_ready = fen;
  assign q_push   = fv_r[TRIG_LAT] && fen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= TRIG_LAT; k++) begin
        fv_r[k] <= 1'b0;
      end
    end else if (fen) begin
      fv_r[0] <= in_valid;
      for (int k = 1; k <= TRIG_LAT; k++) begin
        fv_r[k] <= fv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      roll_r  <= roll;
      pitch_r <= pitch;
      yaw_r   <= yaw;
    end
  end

  eul2dcm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_roll (
    .clk   (clk),
    .en    (fen),
    .angle (roll_r),
    .trig  (q_data.roll)
  );

  eul2dcm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_pitch (
    .clk   (clk),
    .en    (fen),
    .angle (pitch_r),
    .trig  (q_data.pitch)
  );

  eul2dcm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_yaw (
    .clk   (clk),
    .en    (fen),
    .angle (yaw_r),
    .trig  (q_data.yaw)
  );

endmodule

>>> sv/eul2dcm_fifo.sv
// ----------------------------------------------------------------------------
// eul2dcm_fifo
// Short queue of sine / cosine sets between the front and back pipelines
// ----------------------------------------------------------------------------
module eul2dcm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  eul2dcm_pkg::trig6_t push_data,
  output logic                full,
  input  logic                pop,
  output eul2dcm_pkg::trig6_t pop_data,
  output logic                not_empty
);
  import eul2dcm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  trig6_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not follow a lone write");
`endif

endmodule

>>> sv/eul2dcm_back.sv
// ----------------------------------------------------------------------------
// eul2dcm_back
// Matrix products, sums, rounding and saturation, with the output register
// ----------------------------------------------------------------------------
module eul2dcm_back #(
  parameter int FRACTION_BITS = eul2dcm_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  eul2dcm_pkg::trig6_t            q_data,
  output logic                           q_pop,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [eul2dcm_pkg::OUT_TW-1:0] res_data
);
  import eul2dcm_pkg::*;

  localparam int             SUM_W = MAG_W + 2;
  localparam int             RW    = SUM_W + 1;
  localparam int             SH    = 30 - FRACTION_BITS;
  localparam logic [RW-1:0]  RND   = (RW'(1) << SH) >> 1;
  localparam logic [RW-1:0]  LIM   = RW'(1) << FRACTION_BITS;
  localparam int             NST   = 6;
  localparam logic [2*MAG_W-1:0] RND_Q30 = (2*MAG_W)'(1) << 29;

  typedef struct packed {
    sm_t ctcp; sm_t ctsp; sm_t cfsp; sm_t sfst; sm_t cfcp;
    sm_t sfct; sm_t sfsp; sm_t cfst; sm_t sfcp; sm_t cfct;
    sm_t st;   sm_t sp;   sm_t cp;
  } l1_t;

  typedef struct packed {
    sm_t ctcp; sm_t ctsp; sm_t st;   sm_t cfsp; sm_t sfstcp;
    sm_t cfcp; sm_t sfstsp; sm_t sfct; sm_t sfsp; sm_t cfstcp;
    sm_t sfcp; sm_t cfstsp; sm_t cfct;
  } l2_t;

  // q2.30 product, rounded half away from zero on the magnitude
  function automatic sm_t mulq(input sm_t a, input sm_t b);
    logic [2*MAG_W-1:0] p;
    sm_t                r;
    p     = {{MAG_W{1'b0}}, a.mag} * {{MAG_W{1'b0}}, b.mag} + RND_Q30;
    r.neg = a.neg ^ b.neg;
    r.mag = p[MAG_W+29:30];
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] to_s(input sm_t a);
    logic [SUM_W-1:0] m;
    m = SUM_W'(a.mag);
    return a.neg ? -m : m;
  endfunction

  logic             ben;
  logic             bv_r [NST];
  trig6_t           d0_r;
  l1_t              l1_nxt;
  l1_t              l1_r;
  l2_t              l2_nxt;
  l2_t              l2_r;
  logic [SUM_W-1:0] sum_nxt [N_OUT];
  logic [SUM_W-1:0] sum_r   [N_OUT];
  logic [SUM_W-1:0] amag    [N_OUT];
  logic             neg_r   [N_OUT];
  logic [RW-1:0]    rmag_r  [N_OUT];
  logic [RW-1:0]    smag    [N_OUT];
  logic [RW-1:0]    sres    [N_OUT];
  logic [OUT_TW-1:0] res_nxt;
  logic [OUT_TW-1:0] res_r;

  // the whole back pipe holds while a result waits at the output
  assign ben       = !bv_r[NST-1] || res_ready;
  assign q_pop     = ben && q_valid;
  assign res_valid = bv_r[NST-1];
  assign res_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        bv_r[k] <= 1'b0;
      end
    end else if (ben) begin
      bv_r[0] <= q_valid;
      for (int k = 1; k < NST; k++) begin
        bv_r[k] <= bv_r[k-1];
      end
    end
  end

  always_comb begin
    l1_nxt.ctcp = mulq(d0_r.pitch.c, d0_r.yaw.c);
    l1_nxt.ctsp = mulq(d0_r.pitch.c, d0_r.yaw.s);
    l1_nxt.cfsp = mulq(d0_r.roll.c,  d0_r.yaw.s);
    l1_nxt.sfst = mulq(d0_r.roll.s,  d0_r.pitch.s);
    l1_nxt.cfcp = mulq(d0_r.roll.c,  d0_r.yaw.c);
    l1_nxt.sfct = mulq(d0_r.roll.s,  d0_r.pitch.c);
    l1_nxt.sfsp = mulq(d0_r.roll.s,  d0_r.yaw.s);
    l1_nxt.cfst = mulq(d0_r.roll.c,  d0_r.pitch.s);
    l1_nxt.sfcp = mulq(d0_r.roll.s,  d0_r.yaw.c);
    l1_nxt.cfct = mulq(d0_r.roll.c,  d0_r.pitch.c);
    l1_nxt.st   = d0_r.pitch.s;
    l1_nxt.sp   = d0_r.yaw.s;
    l1_nxt.cp   = d0_r.yaw.c;
  end

  always_comb begin
    l2_nxt.ctcp   = l1_r.ctcp;
    l2_nxt.ctsp   = l1_r.ctsp;
    l2_nxt.st     = l1_r.st;
    l2_nxt.cfsp   = l1_r.cfsp;
    l2_nxt.sfstcp = mulq(l1_r.sfst, l1_r.cp);
    l2_nxt.cfcp   = l1_r.cfcp;
    l2_nxt.sfstsp = mulq(l1_r.sfst, l1_r.sp);
    l2_nxt.sfct   = l1_r.sfct;
    l2_nxt.sfsp   = l1_r.sfsp;
    l2_nxt.cfstcp = mulq(l1_r.cfst, l1_r.cp);
    l2_nxt.sfcp   = l1_r.sfcp;
    l2_nxt.cfstsp = mulq(l1_r.cfst, l1_r.sp);
    l2_nxt.cfct   = l1_r.cfct;
  end

  always_comb begin
    sum_nxt[0] = to_s(l2_r.ctcp);
    sum_nxt[1] = to_s(l2_r.ctsp);
    sum_nxt[2] = -to_s(l2_r.st);
    sum_nxt[3] = to_s(l2_r.sfstcp) - to_s(l2_r.cfsp);
    sum_nxt[4] = to_s(l2_r.cfcp) + to_s(l2_r.sfstsp);
    sum_nxt[5] = to_s(l2_r.sfct);
    sum_nxt[6] = to_s(l2_r.sfsp) + to_s(l2_r.cfstcp);
    sum_nxt[7] = to_s(l2_r.cfstsp) - to_s(l2_r.sfcp);
    sum_nxt[8] = to_s(l2_r.cfct);
  end

  always_comb begin
    for (int k = 0; k < N_OUT; k++) begin
      amag[k] = sum_r[k][SUM_W-1] ? -sum_r[k] : sum_r[k];
    end
  end

  always_comb begin
    res_nxt = '0;
    for (int k = 0; k < N_OUT; k++) begin
      smag[k] = (rmag_r[k] > LIM) ? LIM : rmag_r[k];
      sres[k] = neg_r[k] ? -smag[k] : smag[k];
      res_nxt[k*OUT_W +: OUT_W] = sres[k][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      d0_r  <= q_data;
      l1_r  <= l1_nxt;
      l2_r  <= l2_nxt;
      res_r <= res_nxt;
      for (int k = 0; k < N_OUT; k++) begin
        sum_r[k]  <= sum_nxt[k];
        neg_r[k]  <= sum_r[k][SUM_W-1];
        rmag_r[k] <= (RW'(amag[k]) + RND) >> SH;
      end
    end
  end

endmodule
